/* hdl/cvsh_pkg.sv */
// Shared types and constants for the circle versus shape hit test.
// Used by the sine, front, queue, back and top-level modules and the testbench; depends on nothing.
package cvsh_pkg;

  // Configuration register indexes.
  localparam int CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] REG_PLAYER_X      = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_PLAYER_Y      = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_PLAYER_RADIUS = 2'd2;

  // Object shape codes.
  localparam logic CMD_CIRCLE = 1'b0;
  localparam logic CMD_RECT   = 1'b1;

  // Quarter-wave sine polynomial coefficients, Q16.
  localparam logic [16:0] SIN_A = 17'd102944;
  localparam logic [15:0] SIN_B = 16'd42047;
  localparam logic [12:0] SIN_C = 13'd4639;

  // Depth of the queue between front and back.
  localparam int QUEUE_DEPTH = 4;

  typedef logic signed [15:0] coord_t;
  typedef logic signed [16:0] diff_t;
  typedef logic signed [17:0] trig_t;
  typedef logic [11:0]        radius_t;
  typedef logic [15:0]        extent_t;

  // One object as it arrives on the input stream (angle travels apart).
  typedef struct packed {
    logic    cmd;
    coord_t  obj_x;
    coord_t  obj_y;
    radius_t obj_radius;
    extent_t rect_width;
    extent_t rect_length;
    logic    last;
  } obj_t;

  // One classified object handed from the front to the back.
  typedef struct packed {
    logic    cmd;
    diff_t   dx;
    diff_t   dy;
    radius_t obj_radius;
    extent_t rect_width;
    extent_t rect_length;
    trig_t   sin_q16;
    trig_t   cos_q16;
    logic    last;
  } q_entry_t;

endpackage

/* hdl/cvsh_sine.sv */
// Five-stage pipelined Q16 sine from a fifth order quarter-wave polynomial.
// Depends on cvsh_pkg for the coefficients.
module cvsh_sine import cvsh_pkg::*; #(
  parameter int ANGLE_BITS = 12
) (
  input  logic                  clk,
  input  logic                  en,
  input  logic [ANGLE_BITS-1:0] ang,
  output trig_t                 sin_q16
);

  localparam int QW  = ANGLE_BITS - 2;
  localparam int XSH = 18 - ANGLE_BITS;

  logic [1:0]    quad;
  logic [QW-1:0] q;
  logic [QW:0]   qq;
  logic [16:0]   x_in;

  logic [16:0] x1, x2, x3, x4;
  logic        neg1, neg2, neg3, neg4;
  logic [16:0] sq2, sq3;
  logic [15:0] t3;
  logic [16:0] t4;
  logic [33:0] m1;
  logic [29:0] m2;
  logic [32:0] m3;
  logic [33:0] m4;
  logic [16:0] mag;

  always_comb begin
    quad = ang[ANGLE_BITS-1:ANGLE_BITS-2];
    q    = ang[QW-1:0];
    // Odd quadrants run the quarter wave backward.
    qq   = quad[0] ? ({1'b1, {QW{1'b0}}} - {1'b0, q}) : {1'b0, q};
    x_in = 17'(qq) << XSH;
    m1   = x1 * x1;
    m2   = SIN_C * sq2;
    m3   = t3 * sq3;
    m4   = t4 * x4;
    mag  = m4[32:16];
  end

  always_ff @(posedge clk) begin
    if (en) begin
      x1   <= x_in;
      neg1 <= quad[1];

      sq2  <= m1[32:16];
      x2   <= x1;
      neg2 <= neg1;

      t3   <= SIN_B - 16'(m2[29:16]);
      sq3  <= sq2;
      x3   <= x2;
      neg3 <= neg2;

      t4   <= SIN_A - m3[32:16];
      x4   <= x3;
      neg4 <= neg3;

      sin_q16 <= neg4 ? -$signed({1'b0, mag}) : $signed({1'b0, mag});
    end
  end

endmodule

/* hdl/cvsh_front.sv */
// Front end: accepts objects, forms the player offset and computes sine and cosine.
// Depends on cvsh_pkg and cvsh_sine; feeds cvsh_queue.
module cvsh_front import cvsh_pkg::*; #(
  parameter int ANGLE_BITS = 12
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  obj_t                  in_obj,
  input  logic [ANGLE_BITS-1:0] in_angle,
  input  coord_t                player_x,
  input  coord_t                player_y,
  output logic                  push,
  input  logic                  q_full,
  output q_entry_t              push_entry
);

  localparam int STAGES = 5;

  logic [STAGES-1:0] vld;
  q_entry_t          pipe [STAGES];
  q_entry_t          first;
  logic              en;
  logic [ANGLE_BITS-1:0] cos_ang;
  trig_t             sin_v, cos_v;

  // The whole front holds only when its last word cannot enter the queue.
  assign en       = !(vld[STAGES-1] && q_full);
  assign in_ready = en && !rst;
  assign push     = vld[STAGES-1] && !q_full;
  assign cos_ang  = in_angle + {2'b01, {(ANGLE_BITS-2){1'b0}}};

  always_comb begin
    first             = '0;
    first.cmd         = in_obj.cmd;
    first.dx          = {player_x[15], player_x} - {in_obj.obj_x[15], in_obj.obj_x};
    first.dy          = {player_y[15], player_y} - {in_obj.obj_y[15], in_obj.obj_y};
    first.obj_radius  = in_obj.obj_radius;
    first.rect_width  = in_obj.rect_width;
    first.rect_length = in_obj.rect_length;
    first.last        = in_obj.last;
    push_entry         = pipe[STAGES-1];
    push_entry.sin_q16 = sin_v;
    push_entry.cos_q16 = cos_v;
  end

  cvsh_sine #(.ANGLE_BITS(ANGLE_BITS)) u_sin (
    .clk(clk), .en(en), .ang(in_angle), .sin_q16(sin_v)
  );

  cvsh_sine #(.ANGLE_BITS(ANGLE_BITS)) u_cos (
    .clk(clk), .en(en), .ang(cos_ang), .sin_q16(cos_v)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[STAGES-2:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      pipe[0] <= first;
      for (int i = 1; i < STAGES; i++) begin
        pipe[i] <= pipe[i-1];
      end
    end
  end

endmodule

/* hdl/cvsh_queue.sv */
// Short first-in first-out queue of classified objects between front and back.
// Depends on cvsh_pkg for the entry type and depth.
module cvsh_queue import cvsh_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  logic     push,
  input  q_entry_t push_entry,
  output logic     full,
  input  logic     pop,
  output q_entry_t pop_entry,
  output logic     empty
);

  localparam int PW = $clog2(QUEUE_DEPTH);
  localparam int CW = $clog2(QUEUE_DEPTH + 1);

  q_entry_t      slots [QUEUE_DEPTH];
  logic [PW-1:0] wr_ptr, rd_ptr;
  logic [CW-1:0] count;

  assign full      = count == CW'(QUEUE_DEPTH);
  assign empty     = count == '0;
  assign pop_entry = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

`ifndef SYNTHESIS
  a_no_overflow: assert property (@(posedge clk) disable iff (rst) push |-> !full)
    else $error("queue written while full");
  a_no_underflow: assert property (@(posedge clk) disable iff (rst) pop |-> !empty)
    else $error("queue read while empty");
  a_count_up: assert property (@(posedge clk) disable iff (rst)
    push && !pop |=> count == $past(count) + 1'b1)
    else $error("queue count lost a word");
`endif

endmodule

/* hdl/cvsh_back.sv */
// Back end: rotates the offset, clamps to the rectangle or sums circle radii,
// and decides the hit. Depends on cvsh_pkg; reads from cvsh_queue.
module cvsh_back import cvsh_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  logic     q_empty,
  input  q_entry_t q_data,
  output logic     q_pop,
  input  radius_t  player_radius,
  output logic     out_valid,
  input  logic     out_ready,
  output logic     hit,
  output logic     last_out
);

  localparam int STAGES = 6;

  logic [STAGES-1:0] vld;
  logic              en;

  // Stage 0: products.
  logic               cmd0, last0;
  logic [33:0]        ddx0, ddy0;
  logic [25:0]        rs20;
  logic signed [34:0] pxc0, pys0, pyc0, pxs0;
  extent_t            rw0, rl0;
  // Stage 1: rotated offset and circle decision.
  logic               cmd1, last1, chit1;
  logic signed [35:0] lx1, ly1;
  extent_t            rw1, rl1;
  // Stage 2: magnitudes.
  logic               cmd2, last2, chit2;
  logic [35:0]        mx2, my2;
  extent_t            rw2, rl2;
  // Stage 3: excess beyond the half extents.
  logic               cmd3, last3, chit3;
  logic [27:0]        ex3, ey3;
  // Stage 4: squares.
  logic               cmd4, last4, chit4;
  logic [55:0]        exx4, eyy4;
  logic [39:0]        rr4;

  logic [12:0] rs;
  logic [34:0] d2;
  logic [35:0] hwx, hly, dfx, dfy;
  logic [19:0] r_sh;

  assign en    = !(vld[STAGES-1] && !out_ready);
  assign q_pop = en && !q_empty;
  assign out_valid = vld[STAGES-1];

  always_comb begin
    rs   = {1'b0, player_radius} + {1'b0, q_data.obj_radius};
    d2   = {1'b0, ddx0} + {1'b0, ddy0};
    hwx  = {5'b0, rw2, 15'b0};
    hly  = {5'b0, rl2, 15'b0};
    dfx  = mx2 - hwx;
    dfy  = my2 - hly;
    r_sh = {player_radius, 8'b0};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[STAGES-2:0], !q_empty};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      cmd0  <= q_data.cmd;
      last0 <= q_data.last;
      ddx0  <= 34'(q_data.dx) * 34'(q_data.dx);
      ddy0  <= 34'(q_data.dy) * 34'(q_data.dy);
      rs20  <= rs * rs;
      pxc0  <= q_data.dx * q_data.cos_q16;
      pys0  <= q_data.dy * q_data.sin_q16;
      pyc0  <= q_data.dy * q_data.cos_q16;
      pxs0  <= q_data.dx * q_data.sin_q16;
      rw0   <= q_data.rect_width;
      rl0   <= q_data.rect_length;

      cmd1  <= cmd0;
      last1 <= last0;
      chit1 <= d2 <= 35'(rs20);
      lx1   <= 36'(pxc0) + 36'(pys0);
      ly1   <= 36'(pyc0) - 36'(pxs0);
      rw1   <= rw0;
      rl1   <= rl0;

      cmd2  <= cmd1;
      last2 <= last1;
      chit2 <= chit1;
      mx2   <= lx1[35] ? 36'(-lx1) : 36'(lx1);
      my2   <= ly1[35] ? 36'(-ly1) : 36'(ly1);
      rw2   <= rw1;
      rl2   <= rl1;

      cmd3  <= cmd2;
      last3 <= last2;
      chit3 <= chit2;
      ex3   <= (mx2 <= hwx) ? '0 : dfx[35:8];
      ey3   <= (my2 <= hly) ? '0 : dfy[35:8];

      cmd4  <= cmd3;
      last4 <= last3;
      chit4 <= chit3;
      exx4  <= ex3 * ex3;
      eyy4  <= ey3 * ey3;
      rr4   <= r_sh * r_sh;

      last_out <= last4;
      if (cmd4 == CMD_RECT) begin
        hit <= ({1'b0, exx4} + {1'b0, eyy4}) <= 57'(rr4);
      end else begin
        hit <= chit4;
      end
    end
  end

endmodule

/* hdl/circle_vs_shape_hit_test.sv */
// Top level of the circle versus shape hit test.
// Depends on cvsh_pkg, cvsh_front, cvsh_queue and cvsh_back.
//
// Usage: the player circle is set through the write port (cfg_we, cfg_index,
// cfg_data) while no object is in flight. Objects arrive on the s_ channel,
// one word per object: s_tuser carries the shape (0 circle, 1 rotated
// rectangle), s_tlast marks the final object of a frame. Each object gives
// exactly one word on the m_ channel: m_tdata[0] is the hit flag and m_tlast
// echoes the frame marker.
// Throughput is one object per cycle while m_tready stays high. An accepted
// object enters the first of 5 sine/cosine polynomial stages in the front,
// the output of the fifth is written into the queue, and 6 multiply, clamp
// and compare stages in the back follow.
// When m_tready is low the back holds, the queue fills, and s_tready drops
// only once the front's last stage cannot enter the queue.
// Reset is synchronous and clears the player registers and all valid state;
// s_tready is low while rst is high.
module circle_vs_shape_hit_test import cvsh_pkg::*; #(
  parameter int ANGLE_BITS = 12,
  localparam int IN_W = ((76 + ANGLE_BITS + 7) / 8) * 8
) (
  input  logic                 clk,
  input  logic                 rst,
  // Configuration write port.
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [15:0]          cfg_data,
  // Object stream.
  input  logic                 s_tvalid,
  output logic                 s_tready,
  // obj_x, obj_y, obj_radius, rect_width, rect_length, angle, zero fill
  input  logic [IN_W-1:0]      s_tdata,
  input  logic                 s_tuser,   // cmd
  input  logic                 s_tlast,
  // Result stream.
  output logic                 m_tvalid,
  input  logic                 m_tready,
  output logic [7:0]           m_tdata,   // hit, zero fill
  output logic                 m_tlast
);

  coord_t   player_x, player_y;
  radius_t  player_radius;
  obj_t     in_obj;
  logic [ANGLE_BITS-1:0] in_angle;
  logic     push, pop, q_full, q_empty, hit;
  q_entry_t push_entry, pop_entry;

  always_ff @(posedge clk) begin
    if (rst) begin
      player_x      <= '0;
      player_y      <= '0;
      player_radius <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_PLAYER_X:      player_x      <= cfg_data;
        REG_PLAYER_Y:      player_y      <= cfg_data;
        REG_PLAYER_RADIUS: player_radius <= cfg_data[11:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    in_obj.cmd         = s_tuser;
    in_obj.obj_x       = s_tdata[15:0];
    in_obj.obj_y       = s_tdata[31:16];
    in_obj.obj_radius  = s_tdata[43:32];
    in_obj.rect_width  = s_tdata[59:44];
    in_obj.rect_length = s_tdata[75:60];
    in_obj.last        = s_tlast;
    in_angle           = s_tdata[76 +: ANGLE_BITS];
  end

  cvsh_front #(.ANGLE_BITS(ANGLE_BITS)) u_front (
    .clk(clk), .rst(rst),
    .in_valid(s_tvalid), .in_ready(s_tready),
    .in_obj(in_obj), .in_angle(in_angle),
    .player_x(player_x), .player_y(player_y),
    .push(push), .q_full(q_full), .push_entry(push_entry)
  );

  cvsh_queue u_queue (
    .clk(clk), .rst(rst),
    .push(push), .push_entry(push_entry), .full(q_full),
    .pop(pop), .pop_entry(pop_entry), .empty(q_empty)
  );

  cvsh_back u_back (
    .clk(clk), .rst(rst),
    .q_empty(q_empty), .q_data(pop_entry), .q_pop(pop),
    .player_radius(player_radius),
    .out_valid(m_tvalid), .out_ready(m_tready),
    .hit(hit), .last_out(m_tlast)
  );

  assign m_tdata = {7'b0, hit};

endmodule

/* tb/tb_circle_vs_shape_hit_test.sv */
// Self-checking testbench for circle_vs_shape_hit_test: predicts the hit flag of
// every object word from its own fixed-point copy of the geometry.
// Depends on cvsh_pkg and the block's RTL only.
module tb_circle_vs_shape_hit_test;
  import cvsh_pkg::*;

  localparam int ANGLE_W   = 12;
  localparam int QUARTER   = 1 << (ANGLE_W - 2);
  localparam longint TRIG_A = 102944;
  localparam longint TRIG_B = 42047;
  localparam longint TRIG_C = 4639;
  localparam int DRAIN_CYCLES = 16;
  localparam int LONG_HOLD    = 300;
  localparam int MAX_PRINTED  = 40;

  typedef struct {
    logic            cmd;
    coord_t          obj_x;
    coord_t          obj_y;
    radius_t         obj_radius;
    extent_t         rect_width;
    extent_t         rect_length;
    logic [ANGLE_W-1:0] angle;
    logic            last;
  } hostile_t;

  typedef struct {
    logic        hit;
    logic        last;
    int unsigned seq;
  } verdict_t;

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [15:0]          cfg_data = '0;
  logic                 s_tvalid = 1'b0;
  logic                 s_tready;
  logic [87:0]          s_tdata = '0;
  logic                 s_tuser = 1'b0;
  logic                 s_tlast = 1'b0;
  logic                 m_tvalid;
  logic                 m_tready = 1'b0;
  logic [7:0]           m_tdata;
  logic                 m_tlast;

  circle_vs_shape_hit_test #(.ANGLE_BITS(ANGLE_W)) u_top (
    .clk(clk), .rst(rst),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
    .s_tuser(s_tuser), .s_tlast(s_tlast),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tlast(m_tlast)
  );

  always #4 clk = ~clk;

  // Player circle as the block should hold it.
  coord_t  pl_x = '0;
  coord_t  pl_y = '0;
  radius_t pl_radius = '0;

  hostile_t    pending_objs[$];
  verdict_t    hit_queue[$];
  hostile_t    cur_obj;
  hostile_t    next_obj;
  verdict_t    want;
  logic        in_taken = 1'b0;
  logic        steady = 1'b0;
  int          holds_asked = 0;
  int          holds_done = 0;
  int          hold_left = 0;
  int          errors = 0;
  int unsigned n_accepted = 0;
  int unsigned n_circles = 0;
  int unsigned n_rects = 0;
  int unsigned n_hits = 0;
  int unsigned n_settings = 0;

  task automatic flag_mismatch(input string msg);
    errors++;
    // Past the first 40 lines only the count grows.
    if (errors <= MAX_PRINTED) $display("mismatch: %s", msg);
  endtask

  // Quarter-wave polynomial sine, Q16; the angle wraps at a full turn.
  function automatic longint trig_q16(input int unsigned a);
    longint      q, x, x2, t, s;
    int unsigned quad;
    a = a & ((1 << ANGLE_W) - 1);
    quad = (a >> (ANGLE_W - 2)) & 3;
    q = a & (QUARTER - 1);
    if (quad & 1) q = QUARTER - q;
    x = q << (16 - (ANGLE_W - 2));
    x2 = (x * x) >> 16;
    t = (TRIG_C * x2) >> 16;
    t = TRIG_B - t;
    t = (t * x2) >> 16;
    t = TRIG_A - t;
    s = (t * x) >> 16;
    return (quad >= 2) ? -s : s;
  endfunction

  function automatic longint overhang(input longint local_c, input longint half);
    longint m;
    m = (local_c < 0) ? -local_c : local_c;
    if (m <= half) return 0;
    return (m - half) >> 8;
  endfunction

  function automatic logic predict_hit(input hostile_t o);
    longint dx, dy, rs, s, c, lx, ly, ex, ey, r;
    dx = longint'(pl_x) - longint'(o.obj_x);
    dy = longint'(pl_y) - longint'(o.obj_y);
    if (o.cmd == CMD_CIRCLE) begin
      rs = longint'(pl_radius) + longint'(o.obj_radius);
      return (dx * dx + dy * dy) <= rs * rs;
    end
    s = trig_q16(o.angle);
    c = trig_q16(int'(o.angle) + QUARTER);
    lx = dx * c + dy * s;
    ly = dy * c - dx * s;
    ex = overhang(lx, longint'(o.rect_width) << 15);
    ey = overhang(ly, longint'(o.rect_length) << 15);
    r = longint'(pl_radius) << 8;
    return (ex * ex + ey * ey) <= r * r;
  endfunction

  function automatic hostile_t mk(input logic cmd, input int x, input int y, input int rad,
                                  input int w, input int l, input int ang, input logic last);
    hostile_t o;
    o.cmd = cmd;
    o.obj_x = x[15:0];
    o.obj_y = y[15:0];
    o.obj_radius = rad[11:0];
    o.rect_width = w[15:0];
    o.rect_length = l[15:0];
    o.angle = ang[ANGLE_W-1:0];
    o.last = last;
    return o;
  endfunction

  // Mostly objects placed around the player so that hits and misses both occur;
  // the rest are words with every field fully random.
  function automatic hostile_t rand_object();
    hostile_t o;
    int       reach, off, tmp;
    o.cmd = 1'($urandom);
    o.obj_x = 16'($urandom);
    o.obj_y = 16'($urandom);
    o.obj_radius = 12'($urandom);
    o.rect_width = 16'($urandom);
    o.rect_length = 16'($urandom);
    o.angle = ANGLE_W'($urandom);
    o.last = ($urandom_range(7) == 0);
    if ($urandom_range(9) < 8) begin
      if (o.cmd == CMD_CIRCLE) begin
        reach = int'(pl_radius) + int'(o.obj_radius) + 8;
      end else begin
        if ($urandom_range(3) != 0) begin
          o.rect_width = 16'($urandom_range(1023));
          o.rect_length = 16'($urandom_range(1023));
        end
        reach = (int'(o.rect_width) + int'(o.rect_length)) / 2 + int'(pl_radius) + 16;
      end
      off = int'($urandom_range(2 * reach)) - reach;
      tmp = int'(pl_x) + off;
      o.obj_x = tmp[15:0];
      off = int'($urandom_range(2 * reach)) - reach;
      tmp = int'(pl_y) + off;
      o.obj_y = tmp[15:0];
    end
    return o;
  endfunction

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [15:0] val);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    case (idx)
      REG_PLAYER_X:      pl_x = val;
      REG_PLAYER_Y:      pl_y = val;
      REG_PLAYER_RADIUS: pl_radius = val[11:0];
      default: ;
    endcase
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic set_player(input logic [15:0] x, input logic [15:0] y, input logic [15:0] r);
    write_reg(REG_PLAYER_X, x);
    write_reg(REG_PLAYER_Y, y);
    write_reg(REG_PLAYER_RADIUS, r);
    n_settings++;
  endtask

  // Sender stops; wait for every result word, then let the pipeline settle.
  task automatic wait_drained();
    while (pending_objs.size() != 0 || s_tvalid || hit_queue.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic push_random(input int count);
    for (int i = 0; i < count; i++) pending_objs.push_back(rand_object());
  endtask

  // Object driver.
  always @(negedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
    end else if (!s_tvalid || in_taken) begin
      if (pending_objs.size() != 0 && (steady || $urandom_range(99) >= 25)) begin
        next_obj = pending_objs.pop_front();
        cur_obj <= next_obj;
        s_tvalid <= 1'b1;
        s_tdata <= {next_obj.angle, next_obj.rect_length, next_obj.rect_width,
                    next_obj.obj_radius, next_obj.obj_y, next_obj.obj_x};
        s_tuser <= next_obj.cmd;
        s_tlast <= next_obj.last;
      end else begin
        s_tvalid <= 1'b0;
      end
    end
  end

  // Result receiver, which also counts out the long hold-off.
  always @(negedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
    end else if (hold_left > 0) begin
      m_tready <= 1'b0;
      hold_left <= hold_left - 1;
    end else if (holds_done != holds_asked) begin
      m_tready <= 1'b0;
      hold_left <= LONG_HOLD;
      holds_done <= holds_done + 1;
    end else begin
      m_tready <= steady || ($urandom_range(99) >= 25);
    end
  end

  // Monitor: checks result words and records the prediction for each accepted object.
  always @(posedge clk) begin
    if (rst) begin
      in_taken <= 1'b0;
    end else begin
      in_taken <= s_tvalid && s_tready;
      if (m_tvalid && m_tready) begin
        if (hit_queue.size() == 0) begin
          flag_mismatch("result word arrived with no object in flight");
        end else begin
          want = hit_queue.pop_front();
          if (want.hit) n_hits++;
          if (m_tdata[0] !== want.hit)
            flag_mismatch($sformatf("object %0d: hit %b, expected %b",
                                    want.seq, m_tdata[0], want.hit));
          if (m_tlast !== want.last)
            flag_mismatch($sformatf("object %0d: last %b, expected %b",
                                    want.seq, m_tlast, want.last));
        end
      end
      if (s_tvalid && s_tready) begin
        hit_queue.push_back('{hit: predict_hit(cur_obj), last: cur_obj.last, seq: n_accepted});
        n_accepted++;
        if (cur_obj.cmd == CMD_CIRCLE) n_circles++;
        else n_rects++;
      end
    end
  end

  initial begin
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Player at the origin with zero radius, straight out of reset.
    pending_objs.push_back(mk(CMD_CIRCLE, 0, 0, 0, 0, 0, 0, 1'b0));
    pending_objs.push_back(mk(CMD_CIRCLE, 1, 0, 0, 0, 0, 0, 1'b1));
    pending_objs.push_back(mk(CMD_CIRCLE, 0, -1, 0, 0, 0, 0, 1'b0));
    pending_objs.push_back(mk(CMD_CIRCLE, 100, 0, 100, 0, 0, 0, 1'b0));
    pending_objs.push_back(mk(CMD_CIRCLE, 101, 0, 100, 0, 0, 0, 1'b0));
    pending_objs.push_back(mk(CMD_CIRCLE, 60, 80, 100, 65535, 65535, 4095, 1'b1));
    pending_objs.push_back(mk(CMD_RECT, 0, 0, 4095, 0, 0, 0, 1'b0));
    pending_objs.push_back(mk(CMD_RECT, 0, 1, 0, 0, 0, 1000, 1'b0));
    pending_objs.push_back(mk(CMD_RECT, 80, 0, 0, 160, 0, 0, 1'b0));
    pending_objs.push_back(mk(CMD_RECT, 81, 0, 0, 160, 0, 0, 1'b1));
    pending_objs.push_back(mk(CMD_RECT, 0, 80, 0, 160, 0, QUARTER, 1'b0));
    pending_objs.push_back(mk(CMD_RECT, 30, 40, 4095, 100, 200, 2 * QUARTER, 1'b0));
    pending_objs.push_back(mk(CMD_RECT, -30, 40, 0, 100, 200, 3 * QUARTER, 1'b0));
    pending_objs.push_back(mk(CMD_RECT, 50, -50, 0, 200, 200, 4095, 1'b0));
    pending_objs.push_back(mk(CMD_RECT, 50, 50, 0, 120, 30, QUARTER / 2, 1'b1));
    pending_objs.push_back(mk(CMD_CIRCLE, -32768, 32767, 4095, 0, 0, 0, 1'b0));
    pending_objs.push_back(mk(CMD_RECT, 32767, -32768, 0, 65535, 65535, 0, 1'b1));
    wait_drained();

    // Player in one corner at the largest radius; upper data bits must be dropped.
    set_player(16'h7FFF, 16'h8000, 16'hFFFF);
    pending_objs.push_back(mk(CMD_CIRCLE, -32768, 32767, 4095, 0, 0, 0, 1'b0));
    pending_objs.push_back(mk(CMD_CIRCLE, 32767, -32768, 0, 0, 0, 0, 1'b1));
    pending_objs.push_back(mk(CMD_RECT, -32768, 32767, 0, 65535, 65535, QUARTER / 2, 1'b0));
    pending_objs.push_back(mk(CMD_RECT, -32768, 32767, 0, 65535, 65535, 0, 1'b0));
    pending_objs.push_back(mk(CMD_RECT, 32767 - 2000, -32768 + 1000, 0, 0, 0, 300, 1'b1));
    wait_drained();

    for (int p = 0; p < 6; p++) begin
      case (p)
        1: set_player(16'h8000, 16'h7FFF, 16'h0000);
        2: set_player(16'h0000, 16'h0000, 16'h0FFF);
        default: set_player(16'($urandom), 16'($urandom), 16'($urandom));
      endcase
      steady = (p == 1 || p == 3);
      if (p == 3) holds_asked++;
      if (p == 4) begin
        push_random(85);
        wait_drained();
        push_random(90);
      end else begin
        push_random(175);
      end
      wait_drained();
    end
    steady = 1'b0;

    while (hit_queue.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);

    $display("run covered %0d objects (%0d circles, %0d rectangles), %0d predicted hits",
             n_accepted, n_circles, n_rects, n_hits);
    $display("over %0d player settings with random stalls on both streams", n_settings + 1);
    if (errors == 0) begin
      $display("TB_OK");
    end else begin
      $display("%0d mismatches", errors);
      $display("TB_ERROR");
    end
    $finish;
  end

  initial begin
    #3200000;
    $display("timeout with %0d result words outstanding", hit_queue.size());
    $display("TB_ERROR");
    $finish;
  end

endmodule

/* filelist.f */
hdl/cvsh_pkg.sv
hdl/cvsh_sine.sv
hdl/cvsh_front.sv
hdl/cvsh_queue.sv
hdl/cvsh_back.sv
hdl/circle_vs_shape_hit_test.sv
tb/tb_circle_vs_shape_hit_test.sv
